/* design/snapshot_marker_node_defines.svh */
// assertion macros shared by the snapshot marker node rtl
// no dependencies; expects signals named clock and reset where used
`ifndef SNAPSHOT_MARKER_NODE_DEFINES_SVH
`define SNAPSHOT_MARKER_NODE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define SNM_ASSERT_HOLDS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SNM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/snm_pkg.sv */
// shared types and codes of the snapshot marker node
// no dependencies
`timescale 1ns / 1ps

package snm_pkg;

   localparam int LANE_W     = 16;
   localparam int CLK_PACK_W = 64;
   localparam int MARK_W     = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;

   localparam logic [1:0] CMD_DATA   = 2'd0;
   localparam logic [1:0] CMD_MARKER = 2'd1;
   localparam logic [1:0] CMD_START  = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam logic [2:0] KIND_UPDATE   = 3'd0;
   localparam logic [2:0] KIND_MARKER   = 3'd1;
   localparam logic [2:0] KIND_RECORDED = 3'd2;
   localparam logic [2:0] KIND_MESSAGE  = 3'd3;
   localparam logic [2:0] KIND_IGNORED  = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_NODE_ID    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SNAP_LIMIT = 1'b1;

   typedef struct packed {
      logic [1:0]            command;
      logic [1:0]            source;
      logic [CLK_PACK_W-1:0] msg_clock;
   } req_type;

   typedef struct packed {
      logic [2:0]            kind;
      logic [1:0]            peer;
      logic [CLK_PACK_W-1:0] clock_value;
      logic                  last;
      logic                  finished;
      logic [7:0]            snapshot_total;
   } rsp_type;

endpackage

/* design/snm_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module snm_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/snapshot_marker_node.sv */
// channel  | handshake          | payload
// req_     | req_valid/req_stall | req_type: command, source, msg_clock
// rsp_     | rsp_valid/rsp_stall | rsp_type: kind, peer, clock_value, last, finished, total
// csr_     | csr_we             | csr_index, csr_wdata (node_id, snapshot_limit)
// data message or ignored item: accept, then load of the result register once rsp_stall allows
// start or first marker: accept, then one marker a cycle from a peer sequencer while rsp_stall is low
// completion dump: the recorded clock, then a store ram read and an output per stored message,
// with empty channels passed over ahead of the last message; req_stall stays high meanwhile
// reset is synchronous; the message store has no reset and needs no clearing pass
// rsp_stall holds the sequencer; a pending result sits in the output register
// top level of the snapshot marker node; uses snm_pkg, snm_ram and the macro header
`timescale 1ns / 1ps
`include "snapshot_marker_node_defines.svh"

module snapshot_marker_node
   import snm_pkg::*;
#(
   parameter int NODES         = 4,
   parameter int CHANNEL_DEPTH = 16,
   parameter int CLOCK_BITS    = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CH_W        = $clog2(NODES);
   localparam int FILL_W      = $clog2(CHANNEL_DEPTH + 1);
   localparam int STORE_DEPTH = NODES * CHANNEL_DEPTH;
   localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_ONE   = 6'b000010,
      ST_MARK  = 6'b000100,
      ST_DCLK  = 6'b001000,
      ST_DSCAN = 6'b010000,
      ST_DOUT  = 6'b100000
   } state_type;

   typedef logic [NODES-1:0][CLOCK_BITS-1:0] vclock_type;
   typedef logic [NODES-1:0][FILL_W-1:0]     fill_type;

   state_type                state_ff, state_in;
   logic [1:0]               node_id_ff;
   logic [7:0]               limit_ff;
   vclock_type               live_ff, live_in;
   vclock_type               rclk_ff, rclk_in;
   logic [NODES-1:0]         rec_ff, rec_in;
   logic                     active_ff, active_in;
   logic [MARK_W-1:0]        cnt_ff, cnt_in;
   fill_type                 fill_ff, fill_in;
   logic [7:0]               completed_ff, completed_in;
   logic                     stopped_ff, stopped_in;
   logic                     fin_ff, fin_in;
   logic [CH_W-1:0]          peer_ff, peer_in;
   logic [CH_W-1:0]          ch_ff, ch_in;
   logic [FILL_W-1:0]        ent_ff, ent_in;
   logic [2:0]               pend_kind_ff, pend_kind_in;
   logic [CLK_PACK_W-1:0]    pend_clock_ff, pend_clock_in;
   logic                     rsp_valid_ff;
   rsp_type                  rsp_data_ff;

   logic                     req_accept;
   logic                     out_free;
   logic [CH_W-1:0]          me;
   logic [CH_W-1:0]          last_peer;
   logic [CH_W-1:0]          src_idx;
   logic                     src_ok;
   logic                     ignore;
   vclock_type               merged;
   logic                     any_fill;
   logic                     later_fill;
   logic [MARK_W-1:0]        cnt_next;
   logic [7:0]               completed_next;

   logic                     emit;
   logic [2:0]               emit_kind;
   logic [1:0]               emit_peer;
   logic [CLK_PACK_W-1:0]    emit_clock;
   logic                     emit_last;

   logic                     ram_we;
   logic [ADDR_W-1:0]        ram_waddr;
   logic [CLK_PACK_W-1:0]    ram_wdata;
   logic                     ram_re;
   logic [ADDR_W-1:0]        ram_raddr;
   logic [CLK_PACK_W-1:0]    ram_rdata;

   function automatic logic [CLK_PACK_W-1:0] pack_clock(input vclock_type c);
      logic [CLK_PACK_W-1:0] v;
      v = '0;
      for (int i = 0; i < NODES; i++) begin
         v[LANE_W*i +: CLOCK_BITS] = c[i];
      end
      return v;
   endfunction

   function automatic logic [CLK_PACK_W-1:0] clean_clock(input logic [CLK_PACK_W-1:0] m);
      logic [CLK_PACK_W-1:0] v;
      v = '0;
      for (int i = 0; i < NODES; i++) begin
         v[LANE_W*i +: CLOCK_BITS] = m[LANE_W*i +: CLOCK_BITS];
      end
      return v;
   endfunction

   snm_ram #(
      .WIDTH (CLK_PACK_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // an out-of-range node_id acts as the highest node
   assign me        = (int'(node_id_ff) < NODES) ? node_id_ff[CH_W-1:0] : CH_W'(NODES - 1);
   assign last_peer = (int'(me) == NODES - 1) ? CH_W'(NODES - 2) : CH_W'(NODES - 1);
   assign src_ok    = int'(req_data.source) < NODES;
   assign src_idx   = req_data.source[CH_W-1:0];

   assign ignore = stopped_ff || (req_data.command == CMD_UNUSED)
      || ((req_data.command != CMD_START) && !src_ok)
      || ((req_data.command == CMD_START) && active_ff)
      || ((req_data.command == CMD_MARKER)
          && ((src_idx == me) || (active_ff && !rec_ff[src_idx])));

   // element-wise max, then own entry ticks and wraps
   always_comb begin
      logic [CLOCK_BITS-1:0] lane;
      lane = '0;
      for (int i = 0; i < NODES; i++) begin
         lane      = req_data.msg_clock[LANE_W*i +: CLOCK_BITS];
         merged[i] = (lane > live_ff[i]) ? lane : live_ff[i];
      end
      merged[me] = merged[me] + CLOCK_BITS'(1);
   end

   always_comb begin
      any_fill   = 1'b0;
      later_fill = 1'b0;
      for (int i = 0; i < NODES; i++) begin
         if (fill_ff[i] != '0) begin
            any_fill = 1'b1;
            if (i > int'(ch_ff)) begin
               later_fill = 1'b1;
            end
         end
      end
   end

   // a marker on a fresh round counts the local start as well
   assign cnt_next       = active_ff ? (cnt_ff + MARK_W'(1)) : MARK_W'(2);
   assign completed_next = (completed_ff == 8'hFF) ? completed_ff : (completed_ff + 8'd1);

   assign ram_waddr = ADDR_W'(int'(src_idx) * CHANNEL_DEPTH + int'(fill_ff[src_idx]));
   assign ram_wdata = clean_clock(req_data.msg_clock);
   assign ram_raddr = ADDR_W'(int'(ch_ff) * CHANNEL_DEPTH + int'(ent_ff));

   always_comb begin
      state_in      = state_ff;
      live_in       = live_ff;
      rclk_in       = rclk_ff;
      rec_in        = rec_ff;
      active_in     = active_ff;
      cnt_in        = cnt_ff;
      fill_in       = fill_ff;
      completed_in  = completed_ff;
      stopped_in    = stopped_ff;
      fin_in        = fin_ff;
      peer_in       = peer_ff;
      ch_in         = ch_ff;
      ent_in        = ent_ff;
      pend_kind_in  = pend_kind_ff;
      pend_clock_in = pend_clock_ff;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      emit          = 1'b0;
      emit_kind     = KIND_IGNORED;
      emit_peer     = '0;
      emit_clock    = '0;
      emit_last     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (ignore) begin
                  pend_kind_in  = KIND_IGNORED;
                  pend_clock_in = '0;
                  state_in      = ST_ONE;
               end else begin
                  unique case (req_data.command)
                     CMD_DATA: begin
                        live_in = merged;
                        if (rec_ff[src_idx] && (fill_ff[src_idx] < FILL_W'(CHANNEL_DEPTH))) begin
                           ram_we           = 1'b1;
                           fill_in[src_idx] = fill_ff[src_idx] + FILL_W'(1);
                        end
                        pend_kind_in  = KIND_UPDATE;
                        pend_clock_in = pack_clock(merged);
                        state_in      = ST_ONE;
                     end
                     CMD_START, CMD_MARKER: begin
                        if (!active_ff) begin
                           active_in   = 1'b1;
                           rclk_in     = live_ff;
                           live_in[me] = live_ff[me] + CLOCK_BITS'(1);
                           fill_in     = '0;
                           for (int i = 0; i < NODES; i++) begin
                              rec_in[i] = (i != int'(me));
                           end
                        end
                        fin_in  = 1'b0;
                        peer_in = '0;
                        if (req_data.command == CMD_START) begin
                           cnt_in   = MARK_W'(1);
                           state_in = ST_MARK;
                        end else begin
                           rec_in[src_idx] = 1'b0;
                           cnt_in          = cnt_next;
                           if (int'(cnt_next) >= NODES) begin
                              active_in    = 1'b0;
                              cnt_in       = '0;
                              rec_in       = '0;
                              completed_in = completed_next;
                              stopped_in   = (completed_next >= limit_ff);
                              fin_in       = 1'b1;
                           end
                           if (!active_ff) begin
                              state_in = ST_MARK;
                           end else if (int'(cnt_next) >= NODES) begin
                              state_in = ST_DCLK;
                           end else begin
                              state_in = ST_IDLE;
                           end
                        end
                     end
                     default: begin
                        state_in = ST_IDLE;
                     end
                  endcase
               end
            end
         end
         ST_ONE: begin
            if (out_free) begin
               emit       = 1'b1;
               emit_kind  = pend_kind_ff;
               emit_clock = pend_clock_ff;
               emit_last  = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_MARK: begin
            // own slot is skipped without a transaction
            if ((peer_ff == me) || out_free) begin
               if (peer_ff != me) begin
                  emit      = 1'b1;
                  emit_kind = KIND_MARKER;
                  emit_peer = 2'(peer_ff);
                  emit_last = (peer_ff == last_peer) && !fin_ff;
               end
               if (int'(peer_ff) == NODES - 1) begin
                  state_in = fin_ff ? ST_DCLK : ST_IDLE;
               end else begin
                  peer_in = peer_ff + CH_W'(1);
               end
            end
         end
         ST_DCLK: begin
            if (out_free) begin
               emit       = 1'b1;
               emit_kind  = KIND_RECORDED;
               emit_clock = pack_clock(rclk_ff);
               emit_last  = !any_fill;
               ch_in      = '0;
               ent_in     = '0;
               state_in   = any_fill ? ST_DSCAN : ST_IDLE;
            end
         end
         ST_DSCAN: begin
            if (ent_ff < fill_ff[ch_ff]) begin
               ram_re   = 1'b1;
               state_in = ST_DOUT;
            end else if (int'(ch_ff) == NODES - 1) begin
               fill_in  = '0;
               state_in = ST_IDLE;
            end else begin
               ch_in  = ch_ff + CH_W'(1);
               ent_in = '0;
            end
         end
         ST_DOUT: begin
            if (out_free) begin
               emit       = 1'b1;
               emit_kind  = KIND_MESSAGE;
               emit_peer  = 2'(ch_ff);
               emit_clock = ram_rdata;
               emit_last  = ((ent_ff + FILL_W'(1)) == fill_ff[ch_ff]) && !later_fill;
               ent_in     = ent_ff + FILL_W'(1);
               if (emit_last) begin
                  fill_in  = '0;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_DSCAN;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         node_id_ff   <= 2'd0;
         limit_ff     <= 8'd5;
         live_ff      <= '0;
         rclk_ff      <= '0;
         rec_ff       <= '0;
         active_ff    <= 1'b0;
         cnt_ff       <= '0;
         fill_ff      <= '0;
         completed_ff <= 8'd0;
         stopped_ff   <= 1'b0;
         fin_ff       <= 1'b0;
         peer_ff      <= '0;
         ch_ff        <= '0;
         ent_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         live_ff      <= live_in;
         rclk_ff      <= rclk_in;
         rec_ff       <= rec_in;
         active_ff    <= active_in;
         cnt_ff       <= cnt_in;
         fill_ff      <= fill_in;
         completed_ff <= completed_in;
         stopped_ff   <= stopped_in;
         fin_ff       <= fin_in;
         peer_ff      <= peer_in;
         ch_ff        <= ch_in;
         ent_ff       <= ent_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            unique case (csr_index)
               CSR_NODE_ID:    node_id_ff <= csr_wdata[1:0];
               CSR_SNAP_LIMIT: limit_ff   <= csr_wdata;
               default:        limit_ff   <= limit_ff;
            endcase
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      pend_kind_ff  <= pend_kind_in;
      pend_clock_ff <= pend_clock_in;
      if (emit) begin
         rsp_data_ff.kind           <= emit_kind;
         rsp_data_ff.peer           <= emit_peer;
         rsp_data_ff.clock_value    <= emit_clock;
         rsp_data_ff.last           <= emit_last;
         rsp_data_ff.finished       <= stopped_ff;
         rsp_data_ff.snapshot_total <= completed_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `SNM_ASSERT_HOLDS(a_active_count, active_ff, (cnt_ff != '0) && (int'(cnt_ff) < NODES), "marker count out of range in an active round")
   `SNM_ASSERT_HOLDS(a_idle_count, !active_ff, cnt_ff == '0, "marker count left over outside a round")
   `SNM_ASSERT_NEXT(a_stopped_sticky, stopped_ff, stopped_ff, "stopped node restarted")
   `SNM_ASSERT_NEXT(a_total_monotone, 1'b1, completed_ff >= $past(completed_ff), "snapshot total went down")
   `SNM_ASSERT_HOLDS(a_dump_idle_in, (state_ff == ST_DSCAN) || (state_ff == ST_DOUT), !active_ff && !req_accept, "transaction taken or round open during dump")

endmodule

/* tb/snapshot_marker_node_tb.sv */
// self-checking testbench for snapshot_marker_node: directed and random transactions,
// each result predicted from a shadow of the node state and compared field by field
// depends on snm_pkg and the snapshot_marker_node rtl
`timescale 1ns / 1ps

module snapshot_marker_node_tb;
   import snm_pkg::*;

   localparam int PEERS        = 4;
   localparam int SLOT_DEPTH   = 16;
   localparam int CYCLE_CAP    = 1_000_000;
   localparam int SETTLE       = 20;
   localparam int RANDOM_ITEMS = 280;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   snapshot_marker_node uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow of the node state
   logic [1:0]                   node_sel;
   logic [7:0]                   stop_limit;
   logic [PEERS-1:0][LANE_W-1:0] live_vc;
   logic [PEERS-1:0][LANE_W-1:0] saved_vc;
   logic [PEERS-1:0]             listening;
   bit                           round_open;
   int unsigned                  markers_seen;
   logic [CLK_PACK_W-1:0]        held_msg [PEERS][SLOT_DEPTH];
   int unsigned                  held_count [PEERS];
   logic [7:0]                   rounds_done;
   bit                           halted;

   rsp_type     due_results[$];
   rsp_type     batch[$];
   int          error_count     = 0;
   int          items_accepted  = 0;
   int          results_checked = 0;
   bit          steady_flow     = 1'b0;
   int unsigned cycle_count     = 0;

   always #6 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= !steady_flow && ($urandom_range(99) < 11);
   end

   function automatic void clear_shadow();
      node_sel     = 2'd0;
      stop_limit   = 8'd5;
      live_vc      = '0;
      saved_vc     = '0;
      listening    = '0;
      round_open   = 1'b0;
      markers_seen = 0;
      rounds_done  = 8'd0;
      halted       = 1'b0;
      for (int i = 0; i < PEERS; i++) held_count[i] = 0;
   endfunction

   function automatic void add_result(input logic [2:0] kind, input logic [1:0] peer,
                                      input logic [CLK_PACK_W-1:0] value);
      rsp_type r;
      r             = '0;
      r.kind        = kind;
      r.peer        = peer;
      r.clock_value = value;
      batch.push_back(r);
   endfunction

   function automatic void open_round();
      round_open        = 1'b1;
      markers_seen      = 1;
      saved_vc          = live_vc;
      live_vc[node_sel] = live_vc[node_sel] + 1'b1;
      for (int i = 0; i < PEERS; i++) begin
         held_count[i] = 0;
         listening[i]  = (i != node_sel);
         if (i != node_sel) add_result(KIND_MARKER, 2'(i), '0);
      end
   endfunction

   function automatic void close_round();
      add_result(KIND_RECORDED, 2'd0, saved_vc);
      for (int i = 0; i < PEERS; i++) begin
         for (int j = 0; j < held_count[i]; j++) add_result(KIND_MESSAGE, 2'(i), held_msg[i][j]);
         held_count[i] = 0;
      end
      listening    = '0;
      round_open   = 1'b0;
      markers_seen = 0;
      if (rounds_done != 8'hFF) rounds_done = rounds_done + 1'b1;
      if (rounds_done >= stop_limit) halted = 1'b1;
   endfunction

   // applies one accepted transaction to the shadow and queues the results it causes
   function automatic void step_node(input req_type item);
      rsp_type          r;
      logic [LANE_W-1:0] lane;
      logic [1:0]       src;
      src = item.source;
      batch.delete();
      if (halted || item.command == CMD_UNUSED) begin
         add_result(KIND_IGNORED, 2'd0, '0);
      end else if (item.command == CMD_DATA) begin
         for (int i = 0; i < PEERS; i++) begin
            lane = item.msg_clock[LANE_W*i +: LANE_W];
            if (lane > live_vc[i]) live_vc[i] = lane;
         end
         live_vc[node_sel] = live_vc[node_sel] + 1'b1;
         if (listening[src] && held_count[src] < SLOT_DEPTH) begin
            held_msg[src][held_count[src]] = item.msg_clock;
            held_count[src]++;
         end
         add_result(KIND_UPDATE, 2'd0, live_vc);
      end else if (item.command == CMD_START) begin
         if (round_open) add_result(KIND_IGNORED, 2'd0, '0);
         else open_round();
      end else begin
         if (src == node_sel || (round_open && !listening[src])) begin
            add_result(KIND_IGNORED, 2'd0, '0);
         end else begin
            if (!round_open) open_round();
            listening[src] = 1'b0;
            markers_seen++;
            if (markers_seen >= PEERS) close_round();
         end
      end
      for (int k = 0; k < batch.size(); k++) begin
         r                = batch[k];
         r.last           = (k == batch.size() - 1);
         r.finished       = halted;
         r.snapshot_total = rounds_done;
         due_results.push_back(r);
      end
   endfunction

   function automatic bit marker_due(input int ch);
      return round_open && listening[ch];
   endfunction

   // mostly clocks close to the live clock so that the merge goes both ways
   function automatic logic [CLK_PACK_W-1:0] pick_clock();
      logic [CLK_PACK_W-1:0] value;
      if ($urandom_range(9) < 4) begin
         value = {$urandom, $urandom};
      end else begin
         for (int i = 0; i < PEERS; i++)
            value[LANE_W*i +: LANE_W] = live_vc[i] + 16'($urandom_range(4)) - 16'd2;
      end
      return value;
   endfunction

   task automatic send_req(input logic [1:0] command, input logic [1:0] source,
                           input logic [CLK_PACK_W-1:0] value);
      req_type item;
      item.command   = command;
      item.source    = source;
      item.msg_clock = value;
      if (!steady_flow) begin
         while ($urandom_range(99) < 11) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      items_accepted++;
      step_node(item);
   endtask

   // quiet markers cause no result, so give the node time to settle after the last one
   task automatic drain();
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (index == CSR_NODE_ID) node_sel = value[1:0];
      else stop_limit = value;
   endtask

   // one snapshot round: opened if needed, data on random channels, markers until complete
   task automatic play_round(input int small_max, input bit bursty, input bit noisy);
      int data_left [PEERS];
      int c;
      bit busy;
      for (int i = 0; i < PEERS; i++) begin
         if (bursty && $urandom_range(4) == 0) data_left[i] = $urandom_range(20, 14);
         else data_left[i] = $urandom_range(small_max);
      end
      if (!round_open) begin
         if ($urandom_range(1)) send_req(CMD_START, 2'($urandom_range(3)), pick_clock());
         else send_req(CMD_MARKER, 2'(node_sel + 1 + $urandom_range(2)), pick_clock());
      end
      busy = 1'b1;
      while (busy) begin
         c = $urandom_range(PEERS - 1);
         if (noisy && $urandom_range(99) < 8) begin
            send_req(2'($urandom_range(3)), 2'($urandom_range(3)), pick_clock());
         end else if (data_left[c] > 0 && (!marker_due(c) || $urandom_range(3) != 0)) begin
            send_req(CMD_DATA, 2'(c), pick_clock());
            data_left[c]--;
         end else if (marker_due(c)) begin
            send_req(CMD_MARKER, 2'(c), pick_clock());
         end
         busy = 1'b0;
         for (int i = 0; i < PEERS; i++) if (data_left[i] > 0 || marker_due(i)) busy = 1'b1;
      end
   endtask

   task automatic test_clock_merge();
      send_req(CMD_DATA, 2'd3, 64'h0001_0002_0003_0004);
      send_req(CMD_DATA, 2'd1, '0);
      // own entry reaches all ones and wraps
      send_req(CMD_DATA, 2'd2, '1);
      send_req(CMD_DATA, 2'd0, 64'h8000_0000_0000_8000);
      send_req(CMD_UNUSED, 2'd3, '1);
   endtask

   task automatic test_local_round();
      send_req(CMD_START, 2'd0, '0);
      send_req(CMD_DATA, 2'd1, 64'h0000_0000_0010_0000);
      send_req(CMD_DATA, 2'd2, 64'hFFFF_0000_0000_0001);
      send_req(CMD_START, 2'd3, '1);
      send_req(CMD_MARKER, 2'd0, '0);
      send_req(CMD_MARKER, 2'd1, '0);
      send_req(CMD_MARKER, 2'd1, '0);
      send_req(CMD_DATA, 2'd1, 64'h0123_4567_89AB_CDEF);
      send_req(CMD_DATA, 2'd3, 64'hAAAA_5555_AAAA_5555);
      send_req(CMD_MARKER, 2'd3, '0);
      send_req(CMD_MARKER, 2'd2, '0);
   endtask

   task automatic test_marker_round();
      send_req(CMD_DATA, 2'd2, 64'h0000_0000_0000_0007);
      send_req(CMD_MARKER, 2'd2, '1);
      send_req(CMD_DATA, 2'd3, '1);
      send_req(CMD_DATA, 2'd2, 64'h0000_0000_0000_0009);
      send_req(CMD_MARKER, 2'd1, '0);
      send_req(CMD_MARKER, 2'd3, '0);
   endtask

   task automatic test_register_sweep();
      drain();
      write_reg(CSR_SNAP_LIMIT, 8'd1);
      repeat (4) send_req(CMD_DATA, 2'($urandom_range(3)), pick_clock());
      drain();
      write_reg(CSR_SNAP_LIMIT, 8'd255);
      write_reg(CSR_NODE_ID, {6'($urandom), 2'd3});
      play_round(3, 1'b0, 1'b0);
      drain();
      write_reg(CSR_NODE_ID, {6'($urandom), 2'd1});
      play_round(3, 1'b0, 1'b0);
      drain();
      write_reg(CSR_NODE_ID, {6'($urandom), 2'd2});
      play_round(3, 1'b0, 1'b0);
   endtask

   task automatic test_random_rounds();
      int first_item;
      int rounds;
      first_item  = items_accepted;
      rounds      = 0;
      steady_flow = 1'b1;
      while (items_accepted - first_item < RANDOM_ITEMS) begin
         if (items_accepted - first_item > RANDOM_ITEMS / 3) steady_flow = 1'b0;
         play_round(3, 1'b1, 1'b1);
         rounds++;
         if (rounds % 10 == 0) begin
            drain();
            write_reg(CSR_NODE_ID, 8'($urandom));
            write_reg(CSR_SNAP_LIMIT, 8'($urandom_range(255, 100)));
         end
      end
      steady_flow = 1'b0;
   endtask

   task automatic test_limit_zero();
      drain();
      write_reg(CSR_SNAP_LIMIT, 8'd0);
      // a zero limit stops the node at the next completion
      play_round(1, 1'b0, 1'b0);
   endtask

   task automatic test_stopped_node();
      send_req(CMD_DATA, 2'($urandom_range(3)), pick_clock());
      send_req(CMD_MARKER, 2'(node_sel + 1), '0);
      send_req(CMD_START, 2'($urandom_range(3)), '0);
      send_req(CMD_UNUSED, 2'($urandom_range(3)), '1);
      send_req(CMD_DATA, 2'($urandom_range(3)), '1);
   endtask

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_results.size() == 0) begin
            $error("result with none pending: kind %0d clock %0h", rsp_data.kind,
                   rsp_data.clock_value);
            error_count++;
         end else begin
            want = due_results.pop_front();
            results_checked++;
            if (rsp_data.kind !== want.kind) begin
               $error("kind: expected %0d, actual %0d", want.kind, rsp_data.kind);
               error_count++;
            end
            if (rsp_data.peer !== want.peer) begin
               $error("peer: expected %0d, actual %0d", want.peer, rsp_data.peer);
               error_count++;
            end
            if (rsp_data.clock_value !== want.clock_value) begin
               $error("clock_value: expected %0h, actual %0h", want.clock_value,
                      rsp_data.clock_value);
               error_count++;
            end
            if (rsp_data.last !== want.last) begin
               $error("last: expected %0b, actual %0b", want.last, rsp_data.last);
               error_count++;
            end
            if (rsp_data.finished !== want.finished) begin
               $error("finished: expected %0b, actual %0b", want.finished, rsp_data.finished);
               error_count++;
            end
            if (rsp_data.snapshot_total !== want.snapshot_total) begin
               $error("snapshot_total: expected %0d, actual %0d", want.snapshot_total,
                      rsp_data.snapshot_total);
               error_count++;
            end
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_CAP) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("snapshot_marker_node regression: fail");
      $finish;
   end

   initial begin
      clear_shadow();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_clock_merge();
      test_local_round();
      test_marker_round();
      test_register_sweep();
      test_random_rounds();
      test_limit_zero();
      test_stopped_node();
      drain();
      $display("%0d transactions accepted, %0d results checked, %0d cycles", items_accepted,
               results_checked, cycle_count);
      $display("%0d snapshots completed across all node ids, limits from zero to 255",
               rounds_done);
      if (error_count == 0) $display("snapshot_marker_node regression: pass");
      else $display("snapshot_marker_node regression: fail");
      $finish;
   end

endmodule

/* sim.f */
+incdir+design
design/snm_pkg.sv
design/snm_ram.sv
design/snapshot_marker_node.sv
tb/snapshot_marker_node_tb.sv
